### rtl/smbs_pkg.sv
// Package for the SPI master byte shifter: command type, codes and the device map.
`timescale 1ns / 1ps
package smbs_pkg;

    localparam logic [1:0] FUNC_BEGIN  = 2'd0;
    localparam logic [1:0] FUNC_BYTE   = 2'd1;
    localparam logic [1:0] FUNC_FINISH = 2'd2;

    localparam logic [2:0] CS_NONE = 3'b111;

    localparam int QUEUE_DEPTH = 2;

    typedef struct packed {
        logic       is_byte;
        logic       dual;
        logic [2:0] cs;
        logic       mosi;
        logic [7:0] data;
        logic [7:0] rx;
        logic       mis;
    } smbs_cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
    } smbs_q_status_t;

    function automatic logic [2:0] cs_map(input logic [2:0] csel);
        logic [2:0] pat;
        case (csel)
            3'd0:    pat = 3'd6;
            3'd1:    pat = 3'd2;
            3'd2:    pat = 3'd5;
            3'd3:    pat = 3'd3;
            default: pat = CS_NONE;
        endcase
        return pat;
    endfunction

endpackage

### rtl/smbs_front.sv
// Front end: accepts items, tracks select and MOSI state, queues resolved commands.
`timescale 1ns / 1ps
module smbs_front
    import smbs_pkg::*;
(
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  logic [1:0]     s_func,
    input  logic [2:0]     s_chip_select,
    input  logic           s_cs_high,
    input  logic [7:0]     s_tx_byte,
    input  logic           s_dual,
    input  logic           s_verify,
    input  logic [7:0]     s_miso_byte,
    input  smbs_q_status_t q_status,
    output logic           push,
    output smbs_cmd_t      push_cmd
);

    logic [2:0] sel_reg, sel_next;
    logic       lm_reg, lm_next;
    logic       produce;
    logic       accept;
    logic [7:0] data;

    assign s_ready = !q_status.full;
    assign accept  = s_valid && s_ready;
    assign push    = accept && produce;
    assign data    = s_verify ? 8'd0 : s_tx_byte;

    always_comb begin
        sel_next = sel_reg;
        lm_next  = lm_reg;
        produce  = 1'b0;
        push_cmd = '0;
        unique case (s_func)
            FUNC_BEGIN: begin
                if (s_cs_high) begin
                    sel_next = CS_NONE;
                end else begin
                    sel_next      = cs_map(s_chip_select);
                    lm_next       = 1'b0;
                    produce       = 1'b1;
                    push_cmd.cs   = cs_map(s_chip_select);
                    push_cmd.mosi = 1'b0;
                end
            end
            FUNC_BYTE: begin
                produce          = 1'b1;
                push_cmd.is_byte = 1'b1;
                push_cmd.dual    = s_dual;
                push_cmd.cs      = sel_reg;
                push_cmd.data    = data;
                push_cmd.rx      = s_miso_byte;
                push_cmd.mis     = s_verify && (s_miso_byte != s_tx_byte);
                lm_next          = s_dual ? data[1] : data[0];
            end
            FUNC_FINISH: begin
                produce       = 1'b1;
                push_cmd.cs   = CS_NONE;
                push_cmd.mosi = lm_reg;
            end
            default: begin
                produce = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sel_reg <= CS_NONE;
            lm_reg  <= 1'b0;
        end else if (accept) begin
            sel_reg <= sel_next;
            lm_reg  <= lm_next;
        end
    end

endmodule

### rtl/smbs_fifo.sv
// Short command queue between the front end and the pin sequencer.
`timescale 1ns / 1ps
module smbs_fifo
    import smbs_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push,
    input  smbs_cmd_t      push_cmd,
    input  logic           pop,
    output smbs_cmd_t      head,
    output smbs_q_status_t status
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    smbs_cmd_t        mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    assign head         = mem_reg[rd_ptr_reg];
    assign status.full  = (count_reg == CNT_W'(DEPTH));
    assign status.empty = (count_reg == '0);

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn) count_reg <= CNT_W'(DEPTH))
        else $error("queue count overflow");
    assert property (@(posedge aclk) disable iff (!aresetn) pop |-> !status.empty)
        else $error("pop from empty queue");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (push && !pop && count_reg == '0) |=> !status.empty)
        else $error("pushed command lost");

endmodule

### rtl/smbs_back.sv
// Pin sequencer: expands queued commands into pin writes through an output register.
`timescale 1ns / 1ps
module smbs_back
    import smbs_pkg::*;
(
    input  logic           aclk,
    input  logic           aresetn,
    input  smbs_cmd_t      head,
    input  smbs_q_status_t q_status,
    output logic           pop,
    output logic           m_valid,
    input  logic           m_ready,
    output logic [2:0]     m_cs_lines,
    output logic           m_sclk,
    output logic           m_mosi,
    output logic [7:0]     m_rx_byte,
    output logic           m_mismatch,
    output logic           m_last
);

    logic       active_reg;
    smbs_cmd_t  cmd_reg;
    logic [3:0] step_reg;
    logic [7:0] shift_reg;

    logic       m_valid_reg;
    logic [2:0] m_cs_lines_reg;
    logic       m_sclk_reg, m_mosi_reg, m_mismatch_reg, m_last_reg;
    logic [7:0] m_rx_byte_reg;

    logic       load, emit, fin;
    smbs_cmd_t  cur;
    logic [3:0] cur_step;
    logic [7:0] cur_bits;
    logic [2:0] o_cs;
    logic       o_sclk, o_mosi, o_mis, o_last;
    logic [7:0] o_rx;

    assign load = !m_valid_reg || m_ready;
    assign emit = load && (active_reg || !q_status.empty);
    assign pop  = load && !active_reg && !q_status.empty;

    assign cur      = active_reg ? cmd_reg : head;
    assign cur_step = active_reg ? step_reg : 4'd0;
    assign cur_bits = active_reg ? shift_reg : head.data;
    assign fin      = (cur_step == (cur.dual ? 4'd7 : 4'd15));

    always_comb begin
        if (cur.is_byte) begin
            o_cs   = cur.cs | {cur.dual & cur_bits[6], 2'b00};
            o_sclk = cur_step[0];
            o_mosi = cur_bits[7];
            o_rx   = fin ? cur.rx : 8'd0;
            o_mis  = fin && cur.mis;
            o_last = fin;
        end else begin
            o_cs   = cur.cs;
            o_sclk = 1'b0;
            o_mosi = cur.mosi;
            o_rx   = 8'd0;
            o_mis  = 1'b0;
            o_last = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg  <= 1'b0;
            step_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (load) begin
                m_valid_reg <= emit;
            end
            if (emit) begin
                if (cur.is_byte && !fin) begin
                    active_reg <= 1'b1;
                    step_reg   <= cur_step + 1'b1;
                end else begin
                    active_reg <= 1'b0;
                    step_reg   <= '0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            cmd_reg <= head;
        end
        if (emit) begin
            if (cur_step[0]) begin
                shift_reg <= cur.dual ? {cur_bits[5:0], 2'b00} : {cur_bits[6:0], 1'b0};
            end else begin
                shift_reg <= cur_bits;
            end
            m_cs_lines_reg <= o_cs;
            m_sclk_reg     <= o_sclk;
            m_mosi_reg     <= o_mosi;
            m_rx_byte_reg  <= o_rx;
            m_mismatch_reg <= o_mis;
            m_last_reg     <= o_last;
        end
    end

    assign m_valid    = m_valid_reg;
    assign m_cs_lines = m_cs_lines_reg;
    assign m_sclk     = m_sclk_reg;
    assign m_mosi     = m_mosi_reg;
    assign m_rx_byte  = m_rx_byte_reg;
    assign m_mismatch = m_mismatch_reg;
    assign m_last     = m_last_reg;

    assert property (@(posedge aclk) disable iff (!aresetn)
        (active_reg && cmd_reg.dual) |-> (step_reg < 4'd8))
        else $error("dual byte ran past eight writes");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_mismatch_reg) |-> (m_last_reg && m_sclk_reg))
        else $error("mismatch flagged off the final clock-high write");
    assert property (@(posedge aclk) disable iff (!aresetn)
        active_reg |-> (step_reg != 4'd0))
        else $error("active byte at step zero");

endmodule

### rtl/spi_master_byte_shifter.sv
// Top level of the SPI master byte shifter: front end, command queue and pin sequencer.
//
// Usage: each transfer on the s_ channel is one operation (begin select, send byte,
// finish). Each transfer on the m_ channel is one pin write: CS2..CS0, SCLK, MOSI,
// plus rx_byte, mismatch and last on the final write of an item.
// A begin with active-low select gives one write; with active-high select it gives
// none and only clears the stored select pattern. A single-mode byte gives 16 writes,
// a dual-mode byte 8, a finish one. An unused function code gives nothing.
// With the sequencer idle, the first write of an item is registered first in the queue,
// then in the output register.
// Throughput: one pin write per cycle while m_ready is high, set by the sequencer's
// single output register.
// The front end keeps accepting items while the queue (QUEUE_DEPTH entries) has room,
// so up to QUEUE_DEPTH items can wait while a byte is being shifted out; then
// s_ready drops until the sequencer takes the next one.
// Reset: synchronous, active low; the queue empties, no device is selected and the
// stored MOSI level is zero.
// When the receiver holds m_ready low, the current write holds; the queue fills and
// then s_ready drops.
`timescale 1ns / 1ps
module spi_master_byte_shifter
    import smbs_pkg::*;
#(
    parameter int QUEUE_DEPTH_P = QUEUE_DEPTH
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [1:0] s_func,
    input  logic [2:0] s_chip_select,
    input  logic       s_cs_high,
    input  logic [7:0] s_tx_byte,
    input  logic       s_dual,
    input  logic       s_verify,
    input  logic [7:0] s_miso_byte,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [2:0] m_cs_lines,
    output logic       m_sclk,
    output logic       m_mosi,
    output logic [7:0] m_rx_byte,
    output logic       m_mismatch,
    output logic       m_last
);

    smbs_q_status_t q_status;
    smbs_cmd_t      push_cmd, head;
    logic           push, pop;

    smbs_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_func        (s_func),
        .s_chip_select (s_chip_select),
        .s_cs_high     (s_cs_high),
        .s_tx_byte     (s_tx_byte),
        .s_dual        (s_dual),
        .s_verify      (s_verify),
        .s_miso_byte   (s_miso_byte),
        .q_status      (q_status),
        .push          (push),
        .push_cmd      (push_cmd)
    );

    smbs_fifo #(
        .DEPTH (QUEUE_DEPTH_P)
    ) u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head     (head),
        .status   (q_status)
    );

    smbs_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head       (head),
        .q_status   (q_status),
        .pop        (pop),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_cs_lines (m_cs_lines),
        .m_sclk     (m_sclk),
        .m_mosi     (m_mosi),
        .m_rx_byte  (m_rx_byte),
        .m_mismatch (m_mismatch),
        .m_last     (m_last)
    );

endmodule

### tb/spi_master_byte_shifter_test.sv
// Self-checking testbench for the SPI master byte shifter: pin-write predictor and stimulus.
`timescale 1ns / 1ps

typedef struct packed {
    logic [2:0] cs_lines;
    logic       sclk;
    logic       mosi;
    logic [7:0] rx_byte;
    logic       mismatch;
    logic       last;
} pin_write_t;

class pin_sequencer_model;
    logic [2:0] select_lines;
    logic       held_mosi;
    logic [2:0] device_lines[5];
    pin_write_t pending_writes[$];
    int         errors;

    function new();
        select_lines = smbs_pkg::CS_NONE;
        held_mosi = 1'b0;
        device_lines = '{3'd6, 3'd2, 3'd5, 3'd3, smbs_pkg::CS_NONE};
        errors = 0;
    endfunction

    function int pending();
        return pending_writes.size();
    endfunction

    function void add_write(logic [2:0] cs, logic clk, logic mo, logic [7:0] rx, logic mis,
                            logic lst);
        pending_writes.push_back(pin_write_t'{cs, clk, mo, rx, mis, lst});
    endfunction

    // Expands one accepted operation into the pin writes it should cause.
    function void take_op(logic [1:0] f, logic [2:0] csel, logic csh, logic [7:0] tx,
                          logic dl, logic vf, logic [7:0] miso);
        logic [7:0] bits;
        logic [2:0] cs;
        logic       hi, lo, fin, miss;
        int         clocks;
        int         sh;
        case (f)
            smbs_pkg::FUNC_BEGIN: begin
                if (csh) begin
                    select_lines = smbs_pkg::CS_NONE;
                end else begin
                    select_lines = device_lines[(csel > 3'd4) ? 4 : int'(csel)];
                    held_mosi = 1'b0;
                    add_write(select_lines, 1'b0, 1'b0, 8'h00, 1'b0, 1'b1);
                end
            end
            smbs_pkg::FUNC_BYTE: begin
                bits = vf ? 8'h00 : tx;
                miss = vf && (miso != tx);
                clocks = dl ? 4 : 8;
                for (int c = 0; c < clocks; c++) begin
                    fin = (c == clocks - 1);
                    if (dl) begin
                        sh = 7 - 2 * c;
                        hi = bits[sh];
                        lo = bits[sh - 1];
                    end else begin
                        hi = bits[7 - c];
                        lo = 1'b0;
                    end
                    // dual mode: second bit rides on CS2
                    cs = select_lines | {lo, 2'b00};
                    add_write(cs, 1'b0, hi, 8'h00, 1'b0, 1'b0);
                    add_write(cs, 1'b1, hi, fin ? miso : 8'h00, fin & miss, fin);
                    held_mosi = hi;
                end
            end
            smbs_pkg::FUNC_FINISH: begin
                add_write(smbs_pkg::CS_NONE, 1'b0, held_mosi, 8'h00, 1'b0, 1'b1);
            end
            default: begin
            end
        endcase
    endfunction

    function void compare(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            $error("%s: expected %0h, actual %0h", name, want, got);
            errors++;
        end
    endfunction

    function void check_write(pin_write_t got);
        pin_write_t want;
        if (pending_writes.size() == 0) begin
            $error("pin write with none pending: cs_lines=%b sclk=%b mosi=%b last=%b",
                   got.cs_lines, got.sclk, got.mosi, got.last);
            errors++;
            return;
        end
        want = pending_writes.pop_front();
        compare("cs_lines", 32'(want.cs_lines), 32'(got.cs_lines));
        compare("sclk", 32'(want.sclk), 32'(got.sclk));
        compare("mosi", 32'(want.mosi), 32'(got.mosi));
        compare("rx_byte", 32'(want.rx_byte), 32'(got.rx_byte));
        compare("mismatch", 32'(want.mismatch), 32'(got.mismatch));
        compare("last", 32'(want.last), 32'(got.last));
    endfunction
endclass

module spi_master_byte_shifter_test;
    import smbs_pkg::*;

    localparam logic [1:0] FUNC_UNUSED = 2'd3;
    localparam int CYCLE_LIMIT = 500000;
    localparam int OPS_PER_PHASE = 63;

    logic       aclk;
    logic       aresetn;
    logic       s_valid;
    logic       s_ready;
    logic [1:0] s_func;
    logic [2:0] s_chip_select;
    logic       s_cs_high;
    logic [7:0] s_tx_byte;
    logic       s_dual;
    logic       s_verify;
    logic [7:0] s_miso_byte;
    logic       m_valid;
    logic       m_ready;
    logic [2:0] m_cs_lines;
    logic       m_sclk;
    logic       m_mosi;
    logic [7:0] m_rx_byte;
    logic       m_mismatch;
    logic       m_last;

    pin_sequencer_model pins;
    int gap_pct;
    int stall_pct;
    int ops_sent;
    int cycle_count;

    spi_master_byte_shifter dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_func(s_func),
        .s_chip_select(s_chip_select),
        .s_cs_high(s_cs_high),
        .s_tx_byte(s_tx_byte),
        .s_dual(s_dual),
        .s_verify(s_verify),
        .s_miso_byte(s_miso_byte),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_cs_lines(m_cs_lines),
        .m_sclk(m_sclk),
        .m_mosi(m_mosi),
        .m_rx_byte(m_rx_byte),
        .m_mismatch(m_mismatch),
        .m_last(m_last)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("spi_master_byte_shifter test failed");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            pins.check_write(pin_write_t'{m_cs_lines, m_sclk, m_mosi, m_rx_byte,
                                          m_mismatch, m_last});
        m_ready <= ($urandom_range(99) >= stall_pct);
    end

    task automatic send_op(input logic [1:0] f, input logic [2:0] csel, input logic csh,
                           input logic [7:0] tx, input logic dl, input logic vf,
                           input logic [7:0] miso);
        while ($urandom_range(99) < gap_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_func <= f;
        s_chip_select <= csel;
        s_cs_high <= csh;
        s_tx_byte <= tx;
        s_dual <= dl;
        s_verify <= vf;
        s_miso_byte <= miso;
        do @(posedge aclk); while (!s_ready);
        pins.take_op(f, csel, csh, tx, dl, vf, miso);
        if (f != FUNC_UNUSED)
            ops_sent++;
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        do @(posedge aclk); while (pins.pending() != 0);
    endtask

    task automatic send_noise();
        send_op(2'($urandom_range(3)), 3'($urandom), 1'($urandom), 8'($urandom),
                1'($urandom), 1'($urandom), 8'($urandom));
    endtask

    // begin, one to four bytes, finish
    task automatic send_session();
        int         nbytes;
        logic [7:0] tx;
        nbytes = $urandom_range(1, 4);
        send_op(FUNC_BEGIN, 3'($urandom_range(4)), 1'b0, 8'($urandom), 1'($urandom),
                1'($urandom), 8'($urandom));
        repeat (nbytes) begin
            tx = 8'($urandom);
            send_op(FUNC_BYTE, 3'($urandom), 1'($urandom), tx, 1'($urandom), 1'($urandom),
                    $urandom_range(1) ? tx : 8'($urandom));
        end
        send_op(FUNC_FINISH, 3'($urandom), 1'($urandom), 8'($urandom), 1'($urandom),
                1'($urandom), 8'($urandom));
    endtask

    task automatic run_phase(input int gap, input int stall);
        int target;
        gap_pct = gap;
        stall_pct = stall;
        target = ops_sent + OPS_PER_PHASE;
        while (ops_sent < target) begin
            if ($urandom_range(99) < 80)
                send_session();
            else
                send_noise();
        end
        wait_drained();
    endtask

    initial begin
        pins = new();
        gap_pct = 0;
        stall_pct = 0;
        ops_sent = 0;
        cycle_count = 0;
        aresetn <= 1'b0;
        s_valid <= 1'b0;
        s_func <= FUNC_BEGIN;
        s_chip_select <= 3'd0;
        s_cs_high <= 1'b0;
        s_tx_byte <= 8'h00;
        s_dual <= 1'b0;
        s_verify <= 1'b0;
        s_miso_byte <= 8'h00;
        m_ready <= 1'b0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        // directed
        send_op(FUNC_FINISH, 3'd0, 1'b0, 8'h00, 1'b0, 1'b0, 8'h00);
        for (int i = 0; i < 8; i++)
            send_op(FUNC_BEGIN, 3'(i), 1'b0, 8'h00, 1'b0, 1'b0, 8'h00);
        send_op(FUNC_BEGIN, 3'd1, 1'b0, 8'h00, 1'b0, 1'b0, 8'h00);
        send_op(FUNC_BYTE, 3'd0, 1'b0, 8'hff, 1'b0, 1'b0, 8'hff);
        send_op(FUNC_BYTE, 3'd0, 1'b0, 8'h00, 1'b0, 1'b0, 8'h00);
        send_op(FUNC_BYTE, 3'd0, 1'b0, 8'ha5, 1'b0, 1'b0, 8'h5a);
        send_op(FUNC_FINISH, 3'd0, 1'b0, 8'h00, 1'b0, 1'b0, 8'h00);
        send_op(FUNC_BEGIN, 3'd2, 1'b0, 8'h00, 1'b0, 1'b0, 8'h00);
        send_op(FUNC_BYTE, 3'd0, 1'b0, 8'h5a, 1'b1, 1'b0, 8'h00);
        send_op(FUNC_BYTE, 3'd0, 1'b0, 8'hff, 1'b1, 1'b0, 8'hff);
        send_op(FUNC_BYTE, 3'd0, 1'b0, 8'h3c, 1'b0, 1'b1, 8'h3c);
        send_op(FUNC_BYTE, 3'd0, 1'b0, 8'h3c, 1'b0, 1'b1, 8'hc3);
        send_op(FUNC_BYTE, 3'd0, 1'b0, 8'h81, 1'b1, 1'b1, 8'h00);
        send_op(FUNC_FINISH, 3'd0, 1'b0, 8'h00, 1'b0, 1'b0, 8'h00);
        send_op(FUNC_BEGIN, 3'd3, 1'b1, 8'h00, 1'b0, 1'b0, 8'h00);
        send_op(FUNC_BYTE, 3'd0, 1'b0, 8'h81, 1'b0, 1'b0, 8'h7e);
        send_op(FUNC_FINISH, 3'd0, 1'b0, 8'h00, 1'b0, 1'b0, 8'h00);
        send_op(FUNC_UNUSED, 3'd7, 1'b1, 8'hff, 1'b1, 1'b1, 8'hff);
        wait_drained();

        // random sessions and noise operations under varying input gaps and back-pressure
        run_phase(0, 0);
        run_phase(77, 0);
        run_phase(0, 77);
        run_phase(36, 36);

        repeat (40) @(posedge aclk);
        if (pins.errors == 0 && pins.pending() == 0)
            $display("spi_master_byte_shifter test passed");
        else
            $display("spi_master_byte_shifter test failed");
        $finish;
    end
endmodule
